FILE: hdl/hfs_pkg.sv
// Shared types, constants and codes for the heap fit search block.
package hfs_pkg;

   localparam int HEAP_WORDS = 4096;
   localparam int ADDR_W     = 12;
   localparam int SIZE_W     = 13;
   localparam int HDR_W      = SIZE_W + 1;
   localparam int DEPTH      = 1 << ADDR_W;
   localparam int READS_W    = $clog2(HEAP_WORDS + 1);
   localparam int SUM_W      = $clog2(HEAP_WORDS + (1 << SIZE_W)) + 1;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 12;

   localparam logic [CSR_IDX_W-1:0] CSR_FIT_POLICY = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHAIN_BASE = 1'b1;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   localparam logic ST_OK    = 1'b0;
   localparam logic ST_NOMEM = 1'b1;

   typedef enum logic [1:0] {
      POL_FIRST = 2'd0,
      POL_BEST  = 2'd1,
      POL_WORST = 2'd2,
      POL_NEXT  = 2'd3
   } policy_type;

   typedef struct packed {
      policy_type        policy;
      logic [ADDR_W-1:0] chain_base;
   } cfg_type;

   typedef struct packed {
      logic              operation;
      logic [ADDR_W-1:0] header_address;
      logic [SIZE_W-1:0] header_size;
      logic              header_taken;
      logic [SIZE_W-1:0] request_words;
   } cmd_type;

   typedef struct packed {
      logic              status;
      logic [ADDR_W-1:0] block_address;
      logic              at_heap_end;
   } result_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] addr;
      logic [HDR_W-1:0]  wdata;
   } mem_req_type;

endpackage

FILE: hdl/hfs_if.sv
// Request and response channel interfaces of the heap fit search block.
interface hfs_req_if;
   import hfs_pkg::*;
   logic              valid;
   logic              ready;
   logic              operation;
   logic [ADDR_W-1:0] header_address;
   logic [SIZE_W-1:0] header_size;
   logic              header_taken;
   logic [SIZE_W-1:0] request_words;

   modport source (output valid, operation, header_address, header_size, header_taken,
                   request_words, input ready);
   modport sink (input valid, operation, header_address, header_size, header_taken,
                 request_words, output ready);
endinterface

interface hfs_rsp_if;
   import hfs_pkg::*;
   logic              valid;
   logic              ready;
   logic              status;
   logic [ADDR_W-1:0] block_address;
   logic              at_heap_end;

   modport source (output valid, status, block_address, at_heap_end, input ready);
   modport sink (input valid, status, block_address, at_heap_end, output ready);
endinterface

FILE: hdl/hfs_store.sv
// Header store: single-port synchronous RAM with a registered read.
module hfs_store (
   input  logic                       clock,
   input  hfs_pkg::mem_req_type       mreq,
   output logic [hfs_pkg::HDR_W-1:0]  rdata
);
   import hfs_pkg::*;

   logic [HDR_W-1:0] heap_mem [DEPTH];
   logic [HDR_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mreq.we) begin
         heap_mem[mreq.addr] <= mreq.wdata;
      end
      rdata_ff <= heap_mem[mreq.addr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: hdl/hfs_walk.sv
// Chain walker: header writes and policy-driven search, one header read per cycle.
module hfs_walk (
   input  logic                  clock,
   input  logic                  reset,
   input  hfs_pkg::cfg_type      cfg,
   input  logic                  cmd_valid,
   output logic                  cmd_ready,
   input  hfs_pkg::cmd_type      cmd,
   output hfs_pkg::mem_req_type  mreq,
   input  logic [hfs_pkg::HDR_W-1:0] rdata,
   output logic                  res_valid,
   input  logic                  res_free,
   output hfs_pkg::result_type   res
);
   import hfs_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_WALK = 3'b010,
      S_DONE = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] h_ff, h_in;
   logic [ADDR_W-1:0] start_ff, start_in;
   logic [SIZE_W-1:0] req_ff, req_in;
   logic [SUM_W-1:0]  n_ff, n_in;
   logic [READS_W-1:0] reads_ff, reads_in;
   logic              wrapped_ff, wrapped_in;
   logic              have_ff, have_in;
   logic [ADDR_W-1:0] pick_ff, pick_in;
   logic [SIZE_W-1:0] pick_size_ff, pick_size_in;
   logic [ADDR_W-1:0] rover_ff, rover_in;
   logic              rover_set_ff, rover_set_in;
   result_type        res_ff, res_in;

   logic [SIZE_W-1:0] w;
   logic              taken;
   logic              term;
   logic              fits;
   logic              better;
   logic              limit;
   logic              over;
   logic [ADDR_W-1:0] next_h;
   logic [ADDR_W-1:0] s_addr;

   assign w      = rdata[SIZE_W-1:0];
   assign taken  = rdata[SIZE_W];
   assign term   = (w == '0);
   assign fits   = !taken && (w >= req_ff);
   assign next_h = h_ff + w[ADDR_W-1:0] + ADDR_W'(1);
   assign limit  = (reads_ff == READS_W'(HEAP_WORDS));
   assign over   = (n_ff + SUM_W'(req_ff)) > SUM_W'(HEAP_WORDS - 2);
   assign better = !have_ff ||
                   ((cfg.policy == POL_WORST) ? (w > pick_size_ff) : (w < pick_size_ff));
   assign s_addr = rover_set_ff ? rover_ff : cfg.chain_base;

   always_comb begin
      state_in     = state_ff;
      h_in         = h_ff;
      start_in     = start_ff;
      req_in       = req_ff;
      n_in         = n_ff;
      reads_in     = reads_ff;
      wrapped_in   = wrapped_ff;
      have_in      = have_ff;
      pick_in      = pick_ff;
      pick_size_in = pick_size_ff;
      rover_in     = rover_ff;
      rover_set_in = rover_set_ff;
      res_in       = res_ff;
      mreq.we      = 1'b0;
      mreq.addr    = h_ff;
      mreq.wdata   = {cmd.header_taken, cmd.header_size};

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               if (cmd.operation == OP_WRITE) begin
                  mreq.we   = 1'b1;
                  mreq.addr = cmd.header_address;
                  res_in    = '0;
                  state_in  = S_DONE;
               end else begin
                  if (cfg.policy == POL_NEXT) begin
                     rover_in     = s_addr;
                     rover_set_in = 1'b1;
                     h_in         = s_addr;
                     start_in     = s_addr;
                     mreq.addr    = s_addr;
                  end else begin
                     h_in      = cfg.chain_base;
                     start_in  = cfg.chain_base;
                     mreq.addr = cfg.chain_base;
                  end
                  req_in     = cmd.request_words;
                  n_in       = '0;
                  reads_in   = '0;
                  wrapped_in = 1'b0;
                  have_in    = 1'b0;
                  state_in   = S_WALK;
               end
            end
         end
         S_WALK: begin
            h_in      = next_h;
            mreq.addr = next_h;
            reads_in  = reads_ff + READS_W'(1);
            if (limit) begin
               res_in   = '{status: ST_NOMEM, block_address: '0, at_heap_end: 1'b0};
               state_in = S_DONE;
            end else begin
               unique case (cfg.policy)
                  POL_FIRST: begin
                     if (over) begin
                        res_in   = '{status: ST_NOMEM, block_address: '0, at_heap_end: 1'b0};
                        state_in = S_DONE;
                     end else if (term || fits) begin
                        res_in   = '{status: ST_OK, block_address: h_ff, at_heap_end: term};
                        state_in = S_DONE;
                     end else begin
                        n_in = n_ff + SUM_W'(w);
                     end
                  end
                  POL_BEST, POL_WORST: begin
                     if (term) begin
                        res_in = '{status: ST_OK, block_address: (have_ff ? pick_ff : h_ff),
                                   at_heap_end: !have_ff};
                        state_in = S_DONE;
                     end else if (fits && better) begin
                        have_in      = 1'b1;
                        pick_in      = h_ff;
                        pick_size_in = w;
                     end
                  end
                  POL_NEXT: begin
                     priority if (wrapped_ff && (h_ff == start_ff)) begin
                        state_in = S_DONE;
                        if (term) begin
                           res_in   = '{status: ST_OK, block_address: h_ff, at_heap_end: 1'b1};
                           rover_in = h_ff + req_ff[ADDR_W-1:0] + ADDR_W'(1);
                        end else if (have_ff) begin
                           res_in   = '{status: ST_OK, block_address: pick_ff,
                                        at_heap_end: 1'b1};
                           rover_in = pick_ff + req_ff[ADDR_W-1:0] + ADDR_W'(1);
                        end else begin
                           res_in = '{status: ST_NOMEM, block_address: '0, at_heap_end: 1'b0};
                        end
                     end else if (term) begin
                        if (!wrapped_ff) begin
                           have_in    = 1'b1;
                           pick_in    = h_ff;
                           wrapped_in = 1'b1;
                           h_in       = cfg.chain_base;
                           mreq.addr  = cfg.chain_base;
                        end else begin
                           res_in   = '{status: ST_OK, block_address: h_ff, at_heap_end: 1'b1};
                           rover_in = h_ff + req_ff[ADDR_W-1:0] + ADDR_W'(1);
                           state_in = S_DONE;
                        end
                     end else if (fits) begin
                        res_in   = '{status: ST_OK, block_address: h_ff, at_heap_end: 1'b0};
                        rover_in = next_h;
                        state_in = S_DONE;
                     end else begin
                        state_in = S_WALK;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_DONE: begin
            if (res_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rover_ff     <= '0;
         rover_set_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rover_ff     <= rover_in;
         rover_set_ff <= rover_set_in;
      end
   end

   always_ff @(posedge clock) begin
      h_ff         <= h_in;
      start_ff     <= start_in;
      req_ff       <= req_in;
      n_ff         <= n_in;
      reads_ff     <= reads_in;
      wrapped_ff   <= wrapped_in;
      have_ff      <= have_in;
      pick_ff      <= pick_in;
      pick_size_ff <= pick_size_in;
      res_ff       <= res_in;
   end

   assign cmd_ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_DONE);
   assign res       = res_ff;

endmodule

FILE: hdl/heap_fit_search.sv
// Top level: control registers, header store, chain walker and response register.
// A write item is written to the header store when accepted; a search item walks the
// chain. Each result is held in the walker, then in the response register.
// One item is in work at a time; a search reads at most HEAP_WORDS headers.
// A new item is taken while the previous result waits in the response register.
// Reset (synchronous, active high) clears the policy, chain base and roving pointer;
// the header store has no reset.
module heap_fit_search (
   input  logic                              clock,
   input  logic                              reset,
   hfs_req_if.sink                           req_if,
   hfs_rsp_if.source                         rsp_if,
   input  logic                              csr_we,
   input  logic [hfs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [hfs_pkg::CSR_DATA_W-1:0]    csr_data
);
   import hfs_pkg::*;

   policy_type        policy_ff;
   logic [ADDR_W-1:0] chain_base_ff;
   cfg_type           cfg;
   cmd_type           cmd;
   mem_req_type       mreq;
   logic [HDR_W-1:0]  rdata;
   logic              res_valid;
   logic              res_free;
   result_type        res;
   logic              rsp_valid_ff;
   result_type        rsp_res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff     <= POL_FIRST;
         chain_base_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FIT_POLICY: policy_ff     <= policy_type'(csr_data[1:0]);
            CSR_CHAIN_BASE: chain_base_ff <= csr_data[ADDR_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg.policy     = policy_ff;
   assign cfg.chain_base = chain_base_ff;

   assign cmd.operation      = req_if.operation;
   assign cmd.header_address = req_if.header_address;
   assign cmd.header_size    = req_if.header_size;
   assign cmd.header_taken   = req_if.header_taken;
   assign cmd.request_words  = req_if.request_words;

   hfs_store u_store (
      .clock (clock),
      .mreq  (mreq),
      .rdata (rdata)
   );

   hfs_walk u_walk (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd_valid (req_if.valid),
      .cmd_ready (req_if.ready),
      .cmd       (cmd),
      .mreq      (mreq),
      .rdata     (rdata),
      .res_valid (res_valid),
      .res_free  (res_free),
      .res       (res)
   );

   assign res_free = !rsp_valid_ff || rsp_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_free) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (res_free && res_valid) begin
         rsp_res_ff <= res;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.status        = rsp_res_ff.status;
   assign rsp_if.block_address = rsp_res_ff.block_address;
   assign rsp_if.at_heap_end   = rsp_res_ff.at_heap_end;

endmodule

FILE: hdl/hfs_checker.sv
// Port-level checker for heap_fit_search and its bind.
module hfs_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic                       rsp_status,
   input logic [hfs_pkg::ADDR_W-1:0] rsp_block_address,
   input logic                       rsp_at_heap_end
);
   import hfs_pkg::*;

   logic [1:0] pend_ff, pend_in;
   logic       req_acc;
   logic       rsp_acc;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   always_comb begin
      pend_in = pend_ff;
      if (req_acc && !rsp_acc) begin
         pend_in = pend_ff + 2'd1;
      end else if (rsp_acc && !req_acc) begin
         pend_in = pend_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_block_address) && $stable(rsp_at_heap_end))
      else $error("response changed while stalled");

   a_nomem_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_NOMEM) |-> (rsp_block_address == '0) && !rsp_at_heap_end)
      else $error("no-memory response carries an address");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_ready)
      else $error("item accepted while previous item still in work");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pend_ff != 2'd0))
      else $error("response without an outstanding item");

endmodule

bind heap_fit_search hfs_checker u_hfs_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_if.valid),
   .req_ready         (req_if.ready),
   .rsp_valid         (rsp_if.valid),
   .rsp_ready         (rsp_if.ready),
   .rsp_status        (rsp_if.status),
   .rsp_block_address (rsp_if.block_address),
   .rsp_at_heap_end   (rsp_if.at_heap_end)
);
